>>> hw/rtl/slrp_pkg.sv
`timescale 1ns / 1ps

package slrp_pkg;

  // Mark buffer geometry
  localparam int MARK_DEPTH = 32;
  localparam int FILL_W     = $clog2(MARK_DEPTH + 1);
  localparam int IDX_W      = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int RUN_W      = 6;

  // Configuration register indexes
  localparam logic [1:0] CFG_JUMP_CODE      = 2'd0;
  localparam logic [1:0] CFG_MARK_CODE      = 2'd1;
  localparam logic [1:0] CFG_LOOP_CODE      = 2'd2;
  localparam logic [1:0] CFG_LOOP_THRESHOLD = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]       JUMP_CODE_RST = 8'd0;
  localparam logic [7:0]       MARK_CODE_RST = 8'd1;
  localparam logic [7:0]       LOOP_CODE_RST = 8'd2;
  localparam logic [RUN_W-1:0] LOOP_THR_RST  = 6'd4;

  typedef enum logic [1:0] {
    REC_JUMP      = 2'd0,
    REC_MARK      = 2'd1,
    REC_LOOP_HDR  = 2'd2,
    REC_LOOP_PAIR = 2'd3
  } rec_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PAIR,
    ST_JUMP
  } slrp_state_t;

  typedef struct packed {
    logic               mode;
    logic [7:0]         line_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_item_t;

  typedef struct packed {
    rec_kind_t          record_kind;
    logic [7:0]         type_byte;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [RUN_W-1:0]   run_count;
    logic               last_of_run;
  } out_item_t;

endpackage

>>> hw/rtl/scan_line_record_packer_unit.sv
`timescale 1ns / 1ps

// Scan-line record packer. Points arrive as (mode, type, x, y); a point equal
// to the last kept one is dropped, marks are buffered in a 32-entry coordinate
// memory, and a jump, an end-of-list beat or a mark that overflows the buffer
// flushes that buffer as single mark records or as a loop header plus bare
// pairs, followed by the jump record after a jump. The accepting beat issues
// the first buffer read; then one record leaves per cycle while the output
// side does not stall, as the mark memory has a registered read port and is
// read one entry at a time. A beat that yields no record leaves the block
// ready for the next point; otherwise no new input is taken until the last
// record of a flush is loaded into the output register; that register lets
// the input side run on while the final record still waits downstream.
// Configuration writes must only be issued while the block is idle.
module scan_line_record_packer_unit
  import slrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  // Configuration registers
  logic [7:0]       jump_code_r;
  logic [7:0]       mark_code_r;
  logic [7:0]       loop_code_r;
  logic [RUN_W-1:0] loop_thr_r;

  // Control state
  slrp_state_t        state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [FILL_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic signed [31:0] last_x_r, last_x_nxt;
  logic signed [31:0] last_y_r, last_y_nxt;
  logic               loop_r, loop_nxt;
  logic               pend_jump_r, pend_jump_nxt;
  logic               pend_mark_r, pend_mark_nxt;
  logic [7:0]         pend_type_r, pend_type_nxt;
  logic signed [31:0] pend_x_r, pend_x_nxt;
  logic signed [31:0] pend_y_r, pend_y_nxt;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r, out_nxt;
  logic      out_load;
  logic      out_free;

  // Mark memory, {x, y} per entry
  logic [63:0]      mark_mem [MARK_DEPTH];
  logic [63:0]      rd_data_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [63:0]      mem_wdata;

  // Decode helpers
  logic in_fire;
  logic fresh;
  logic is_jump, is_mark;
  logic has_fill, buf_full;
  logic start_flush, force_loop;
  logic pair_done;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign fresh     = (in_data.pos_x != last_x_r) || (in_data.pos_y != last_y_r);
  assign is_jump   = (in_data.line_type == jump_code_r);
  assign is_mark   = (in_data.line_type == mark_code_r);
  assign has_fill  = (fill_r != '0);
  assign buf_full  = (fill_r == FILL_W'(MARK_DEPTH));
  assign pair_done = (rd_idx_r == fill_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_code_r <= JUMP_CODE_RST;
      mark_code_r <= MARK_CODE_RST;
      loop_code_r <= LOOP_CODE_RST;
      loop_thr_r  <= LOOP_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_JUMP_CODE:      jump_code_r <= cfg_wdata;
        CFG_MARK_CODE:      mark_code_r <= cfg_wdata;
        CFG_LOOP_CODE:      loop_code_r <= cfg_wdata;
        CFG_LOOP_THRESHOLD: loop_thr_r  <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state, memory access and output record
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    loop_nxt      = loop_r;
    pend_jump_nxt = pend_jump_r;
    pend_mark_nxt = pend_mark_r;
    pend_type_nxt = pend_type_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    out_load      = 1'b0;
    out_nxt       = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[IDX_W-1:0];
    mem_wdata     = {in_data.pos_x, in_data.pos_y};
    mem_re        = 1'b0;
    mem_raddr     = '0;
    start_flush   = 1'b0;
    force_loop    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.mode) begin
            // end of list
            start_flush   = has_fill;
            pend_jump_nxt = 1'b0;
            pend_mark_nxt = 1'b0;
            last_x_nxt    = -32'sd1;
            last_y_nxt    = -32'sd1;
          end else if (is_jump && fresh) begin
            pend_jump_nxt = 1'b1;
            pend_mark_nxt = 1'b0;
            pend_type_nxt = in_data.line_type;
            pend_x_nxt    = in_data.pos_x;
            pend_y_nxt    = in_data.pos_y;
            last_x_nxt    = in_data.pos_x;
            last_y_nxt    = in_data.pos_y;
            if (has_fill) begin
              start_flush = 1'b1;
            end else begin
              state_nxt = ST_JUMP;
            end
          end else if (is_mark && fresh) begin
            last_x_nxt = in_data.pos_x;
            last_y_nxt = in_data.pos_y;
            if (buf_full) begin
              // overflow: drain as a loop run, park the new mark
              start_flush   = 1'b1;
              force_loop    = 1'b1;
              pend_jump_nxt = 1'b0;
              pend_mark_nxt = 1'b1;
              pend_x_nxt    = in_data.pos_x;
              pend_y_nxt    = in_data.pos_y;
            end else begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
            end
          end
          if (start_flush) begin
            mem_re     = 1'b1;
            mem_raddr  = '0;
            rd_idx_nxt = FILL_W'(1);
            loop_nxt   = force_loop || (7'(fill_r) > 7'(loop_thr_r));
            state_nxt  = (force_loop || (7'(fill_r) > 7'(loop_thr_r))) ? ST_HDR : ST_PAIR;
          end
        end
      end

      ST_HDR: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.record_kind = REC_LOOP_HDR;
          out_nxt.type_byte   = loop_code_r;
          out_nxt.out_x       = '0;
          out_nxt.out_y       = '0;
          out_nxt.run_count   = RUN_W'(fill_r);
          out_nxt.last_of_run = 1'b0;
          state_nxt           = ST_PAIR;
        end
      end

      ST_PAIR: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.record_kind = loop_r ? REC_LOOP_PAIR : REC_MARK;
          out_nxt.type_byte   = loop_r ? 8'd0 : mark_code_r;
          out_nxt.out_x       = rd_data_r[63:32];
          out_nxt.out_y       = rd_data_r[31:0];
          out_nxt.run_count   = '0;
          out_nxt.last_of_run = pair_done && !pend_jump_r;
          if (pair_done) begin
            // buffer drained; a parked mark lands in entry 0
            if (pend_mark_r) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = {pend_x_r, pend_y_r};
              fill_nxt  = FILL_W'(1);
            end else begin
              fill_nxt = '0;
            end
            pend_mark_nxt = 1'b0;
            state_nxt     = pend_jump_r ? ST_JUMP : ST_IDLE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt = rd_idx_r + FILL_W'(1);
          end
        end
      end

      ST_JUMP: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.record_kind = REC_JUMP;
          out_nxt.type_byte   = pend_type_r;
          out_nxt.out_x       = pend_x_r;
          out_nxt.out_y       = pend_y_r;
          out_nxt.run_count   = '0;
          out_nxt.last_of_run = 1'b1;
          pend_jump_nxt       = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      last_x_r    <= -32'sd1;
      last_y_r    <= -32'sd1;
      loop_r      <= 1'b0;
      pend_jump_r <= 1'b0;
      pend_mark_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      loop_r      <= loop_nxt;
      pend_jump_r <= pend_jump_nxt;
      pend_mark_r <= pend_mark_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_type_r <= pend_type_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  // Mark memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mark_mem[mem_raddr];
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MARK_DEPTH))
    else $error("mark fill count beyond buffer depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("mark memory read and write in the same cycle");

  a_hdr_then_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_nxt.record_kind == REC_LOOP_HDR) |=> (state_r == ST_PAIR))
    else $error("loop header not followed by pair readout");

  a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.record_kind == REC_LOOP_HDR) |->
      (out_data_r.run_count != '0 && !out_data_r.last_of_run))
    else $error("loop header with empty run or marked as last");

endmodule
